// File: hw/rtl/sorttab_pkg.sv
// ----------------------------------------------------------------------------
// sorttab_pkg
// Shared widths, codes and controller/datapath interface types for the
// sortable element table.
// ----------------------------------------------------------------------------
package sorttab_pkg;

    // Default table geometry
    localparam int CAPACITY_DEF     = 64;
    localparam int ELEMENT_BITS_DEF = 32;

    // Field widths of one command and one result
    localparam int OP_W         = 3;
    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 6;
    localparam int STATUS_W     = 2;
    localparam int POSITION_W   = 6;
    localparam int READ_VALUE_W = 32;
    localparam int COUNT_W      = 7;

    // Stream packing
    localparam int S_TUSER_W = OP_W;
    localparam int VALUE_LSB = 0;
    localparam int INDEX_LSB = VALUE_LSB + VALUE_W;
    localparam int S_TDATA_W = ((INDEX_LSB + INDEX_W + 7) / 8) * 8;
    localparam int M_TDATA_BITS = STATUS_W + 1 + POSITION_W + READ_VALUE_W + COUNT_W;
    localparam int M_TDATA_W = ((M_TDATA_BITS + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the incoming transaction, clear result fields
        logic append;      // store value at the end, or flag full
        logic set_range;   // flag index past count
        logic scan_start;  // load scan pointer and limit for the current command
        logic scan_step;   // issue one read, process the previous one
        logic drop_last;   // shrink the fill count after delete
        logic sort_init;   // reset the sort outer position
        logic sort_store;  // write back the minimum, advance outer position
        logic out_load;    // move the result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_ge_fill;
        logic            scan_done;
        logic            sort_done;
        logic            out_busy;
    } stat_t;

endpackage

// File: hw/rtl/sorttab_ctrl.sv
// ----------------------------------------------------------------------------
// sorttab_ctrl
// Command sequencer: accepts one transaction, steps the datapath through
// append, scan or sort passes, then hands the result to the output register.
// ----------------------------------------------------------------------------
module sorttab_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output sorttab_pkg::cmd_t   cmd,
    input  sorttab_pkg::stat_t  stat
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DISPATCH   = 3'd1;
    localparam logic [2:0] S_SCAN       = 3'd2;
    localparam logic [2:0] S_SORT_OUTER = 3'd3;
    localparam logic [2:0] S_SORT_SCAN  = 3'd4;
    localparam logic [2:0] S_RESP       = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (stat.op)
                    sorttab_pkg::OP_APPEND: begin
                        cmd.append = 1'b1;
                        state_next = S_RESP;
                    end
                    sorttab_pkg::OP_DELETE,
                    sorttab_pkg::OP_READ: begin
                        if (stat.idx_ge_fill) begin
                            cmd.set_range = 1'b1;
                            state_next    = S_RESP;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    sorttab_pkg::OP_FIND: begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    sorttab_pkg::OP_SORT: begin
                        cmd.sort_init = 1'b1;
                        state_next    = S_SORT_OUTER;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    cmd.drop_last = (stat.op == sorttab_pkg::OP_DELETE);
                    state_next    = S_RESP;
                end
            end
            S_SORT_OUTER: begin
                if (stat.sort_done) begin
                    state_next = S_RESP;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SORT_SCAN;
                end
            end
            S_SORT_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    cmd.sort_store = 1'b1;
                    state_next     = S_SORT_OUTER;
                end
            end
            S_RESP: begin
                // hold until the output register frees up
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/sorttab_dp.sv
// ----------------------------------------------------------------------------
// sorttab_dp
// Datapath: entry memory, fill count, scan pointer with registered read
// pipeline, sort minimum register, result fields and output register.
// ----------------------------------------------------------------------------
module sorttab_dp #(
    parameter int CAPACITY     = sorttab_pkg::CAPACITY_DEF,
    parameter int ELEMENT_BITS = sorttab_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [sorttab_pkg::OP_W-1:0]         s_operation,
    input  logic [sorttab_pkg::VALUE_W-1:0]      s_value,
    input  logic [sorttab_pkg::INDEX_W-1:0]      s_index,
    input  sorttab_pkg::cmd_t                    cmd,
    output sorttab_pkg::stat_t                   stat,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [sorttab_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IW = (CNT_W > sorttab_pkg::INDEX_W) ? CNT_W : sorttab_pkg::INDEX_W;
    localparam int VW = (ELEMENT_BITS > sorttab_pkg::VALUE_W) ?
                        ELEMENT_BITS : sorttab_pkg::VALUE_W;
    localparam int RW = (ELEMENT_BITS > sorttab_pkg::READ_VALUE_W) ?
                        ELEMENT_BITS : sorttab_pkg::READ_VALUE_W;
    localparam int PW = (ADDR_W > sorttab_pkg::POSITION_W) ?
                        ADDR_W : sorttab_pkg::POSITION_W;
    localparam int CW = (CNT_W > sorttab_pkg::COUNT_W) ? CNT_W : sorttab_pkg::COUNT_W;

    logic [ELEMENT_BITS-1:0] mem [CAPACITY];

    logic [sorttab_pkg::OP_W-1:0]       op_reg;
    logic [ELEMENT_BITS-1:0]            val_reg;
    logic [sorttab_pkg::INDEX_W-1:0]    idx_reg;
    logic [CNT_W-1:0]                   fill_reg;
    logic [CNT_W-1:0]                   ptr_reg;
    logic [CNT_W-1:0]                   end_reg;
    logic [CNT_W-1:0]                   a_reg;
    logic                               pend_reg;
    logic [ADDR_W-1:0]                  pend_addr_reg;
    logic [ELEMENT_BITS-1:0]            rd_data_reg;
    logic [ELEMENT_BITS-1:0]            cur_reg;
    logic [sorttab_pkg::STATUS_W-1:0]   status_reg;
    logic                               found_reg;
    logic [ADDR_W-1:0]                  pos_reg;
    logic [ELEMENT_BITS-1:0]            rdval_reg;
    logic                               m_tvalid_reg;
    logic [sorttab_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    logic [VW-1:0]           val_w;
    logic [IW-1:0]           idx_w;
    logic [IW-1:0]           fill_w;
    logic [CNT_W-1:0]        idx_cnt;
    logic                    full;
    logic                    rd_issue;
    logic                    proc;
    logic                    is_first;
    logic                    cur_gt;
    logic [CNT_W-1:0]        scan_first;
    logic [CNT_W-1:0]        scan_end;
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic [ELEMENT_BITS-1:0] wdata;
    logic [PW-1:0]           pos_w;
    logic [RW-1:0]           rdval_w;
    logic [CW-1:0]           count_w;

    assign val_w    = VW'(s_value);
    assign idx_w    = IW'(idx_reg);
    assign fill_w   = IW'(fill_reg);
    assign idx_cnt  = idx_w[CNT_W-1:0];
    assign full     = (fill_reg == CNT_W'(CAPACITY));
    assign rd_issue = cmd.scan_step && (ptr_reg < end_reg);
    assign proc     = cmd.scan_step && pend_reg;
    assign is_first = (pend_addr_reg == a_reg[ADDR_W-1:0]);
    assign cur_gt   = (cur_reg > rd_data_reg);

    assign pos_w   = PW'(pos_reg);
    assign rdval_w = RW'(rdval_reg);
    assign count_w = CW'(fill_reg);

    always_comb begin
        unique case (op_reg)
            sorttab_pkg::OP_FIND:   scan_first = '0;
            sorttab_pkg::OP_DELETE: scan_first = idx_cnt + CNT_W'(1);
            sorttab_pkg::OP_READ:   scan_first = idx_cnt;
            default:                scan_first = a_reg;
        endcase
        scan_end = (op_reg == sorttab_pkg::OP_READ) ? idx_cnt + CNT_W'(1) : fill_reg;
    end

    // single write port
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = cur_reg;
        priority if (cmd.append && !full) begin
            we    = 1'b1;
            waddr = fill_reg[ADDR_W-1:0];
            wdata = val_reg;
        end else if (cmd.sort_store) begin
            we    = 1'b1;
            waddr = a_reg[ADDR_W-1:0];
        end else if (proc && op_reg == sorttab_pkg::OP_DELETE) begin
            // shift the entry down one slot
            we    = 1'b1;
            waddr = pend_addr_reg - ADDR_W'(1);
            wdata = rd_data_reg;
        end else if (proc && op_reg == sorttab_pkg::OP_SORT && !is_first && cur_gt) begin
            // exchange: larger value goes back, smaller one is kept
            we    = 1'b1;
            waddr = pend_addr_reg;
        end else begin
            // hold the memory
            we    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[ptr_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.append && !full) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (cmd.drop_last) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
            if (cmd.scan_start) begin
                pend_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                pend_reg <= rd_issue;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_operation;
            val_reg    <= val_w[ELEMENT_BITS-1:0];
            idx_reg    <= s_index;
            status_reg <= sorttab_pkg::ST_DONE;
            found_reg  <= 1'b0;
            pos_reg    <= '0;
            rdval_reg  <= '0;
        end
        if (cmd.set_range) begin
            status_reg <= sorttab_pkg::ST_RANGE;
        end
        if (cmd.append && full) begin
            status_reg <= sorttab_pkg::ST_FULL;
        end
        if (cmd.sort_init) begin
            a_reg <= '0;
        end else if (cmd.sort_store) begin
            a_reg <= a_reg + CNT_W'(1);
        end
        if (cmd.scan_start) begin
            ptr_reg <= scan_first;
            end_reg <= scan_end;
        end else if (rd_issue) begin
            ptr_reg       <= ptr_reg + CNT_W'(1);
            pend_addr_reg <= ptr_reg[ADDR_W-1:0];
        end
        if (proc) begin
            unique case (op_reg)
                sorttab_pkg::OP_FIND: begin
                    if (rd_data_reg == val_reg) begin
                        found_reg <= 1'b1;
                        pos_reg   <= pend_addr_reg;
                    end
                end
                sorttab_pkg::OP_READ: begin
                    rdval_reg <= rd_data_reg;
                end
                sorttab_pkg::OP_SORT: begin
                    if (is_first || cur_gt) begin
                        cur_reg <= rd_data_reg;
                    end
                end
                default: begin
                end
            endcase
        end
        if (cmd.out_load) begin
            m_tdata_reg <= sorttab_pkg::M_TDATA_W'({
                count_w[sorttab_pkg::COUNT_W-1:0],
                rdval_w[sorttab_pkg::READ_VALUE_W-1:0],
                pos_w[sorttab_pkg::POSITION_W-1:0],
                found_reg,
                status_reg
            });
        end
    end

    assign stat.op          = op_reg;
    assign stat.idx_ge_fill = (idx_w >= fill_w);
    assign stat.scan_done   = !pend_reg && !(ptr_reg < end_reg);
    assign stat.sort_done   = (a_reg >= fill_reg);
    assign stat.out_busy    = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: hw/rtl/sortable_element_table_top.sv
// ----------------------------------------------------------------------------
// sortable_element_table_top
// Bounded table of unsigned elements with append, delete, find, sort, read.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side transaction carries one command (operation in s_tuser,
//   value and index in s_tdata). Exactly one result transaction follows on
//   the master side with status, found, position, read_value and count.
//   Commands are handled one at a time; s_tready is high only while the
//   block waits for a command.
// Work per command (n = fill count):
//   append, unused codes, out-of-range delete/read: no memory scan
//   read: one entry read; find: scans all n entries; delete at i: shifts entries i+1 to n-1
//   sort: one scan of the single-read-port entry memory from each outer
//   position of the exchange sort to the end.
// Result register: a finished result waits in the output register; the block
//   takes the next command while it waits, and only stalls at the end of
//   that command if the receiver still holds m_tready low.
// Reset: aresetn (synchronous, active low) empties the table and drops any
//   pending result. Entry storage is not cleared; entries past the count are
//   never read.
// ----------------------------------------------------------------------------
module sortable_element_table_top #(
    parameter int CAPACITY     = sorttab_pkg::CAPACITY_DEF,
    parameter int ELEMENT_BITS = sorttab_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] value, [37:32] index, [39:38] zero
    input  logic [sorttab_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] operation
    input  logic [sorttab_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [2] found, [8:3] position, [40:9] read_value, [47:41] count
    output logic [sorttab_pkg::M_TDATA_W-1:0]   m_tdata
);

    sorttab_pkg::cmd_t  cmd;
    sorttab_pkg::stat_t stat;

    sorttab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sorttab_dp #(
        .CAPACITY     (CAPACITY),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_operation (s_tuser[sorttab_pkg::OP_W-1:0]),
        .s_value     (s_tdata[sorttab_pkg::VALUE_LSB +: sorttab_pkg::VALUE_W]),
        .s_index     (s_tdata[sorttab_pkg::INDEX_LSB +: sorttab_pkg::INDEX_W]),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule

// File: verif/sortable_element_table_top_tb.sv
// ----------------------------------------------------------------------------
// sortable_element_table_top_tb
// Self-checking bench for the sortable element table. It sends commands
// (append, delete, find, sort, read and the unused codes) over the slave
// stream and keeps a shadow copy of the table and its fill count. From that
// copy it predicts each result transaction and checks it field by field on
// the master stream. Both streams idle at random, and one long receiver
// hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module sortable_element_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = sorttab_pkg::CAPACITY_DEF;
    localparam logic [sorttab_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [sorttab_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;
    localparam int MAX_PRINTED = 30;

    // Field layout of one result, count in the top bits and status at bit 0
    typedef struct packed {
        logic [sorttab_pkg::COUNT_W-1:0]      count;
        logic [sorttab_pkg::READ_VALUE_W-1:0] read_value;
        logic [sorttab_pkg::POSITION_W-1:0]   position;
        logic                                 found;
        logic [sorttab_pkg::STATUS_W-1:0]     status;
    } result_t;

    logic                              aclk;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [sorttab_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [sorttab_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [sorttab_pkg::M_TDATA_W-1:0] m_tdata;

    // Shadow of the table contents
    logic [sorttab_pkg::VALUE_W-1:0] entry_shadow [TABLE_DEPTH];
    int                              fill_shadow = 0;
    result_t                         expected_results [$];

    logic [sorttab_pkg::VALUE_W-1:0] value_pool [6];
    bit                 idle_en    = 1'b1;
    int                 rx_hold    = 0;
    int                 rx_gap     = 0;
    int                 cmds_issued = 0;
    int                 err_count  = 0;

    sortable_element_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("sortable_element_table_top_tb: FAIL");
        $finish;
    end

    // Mostly back to back, sometimes a short gap, rarely a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < MAX_PRINTED)
            $display("%0t ns: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic void sort_shadow();
        logic [sorttab_pkg::VALUE_W-1:0] key;
        int j;
        for (int i = 1; i < fill_shadow; i++) begin
            key = entry_shadow[i];
            j = i - 1;
            while (j >= 0 && entry_shadow[j] > key) begin
                entry_shadow[j + 1] = entry_shadow[j];
                j--;
            end
            entry_shadow[j + 1] = key;
        end
    endfunction

    // Apply one command to the shadow table and return its result
    function automatic result_t predict_command(
        input logic [sorttab_pkg::OP_W-1:0]    op,
        input logic [sorttab_pkg::VALUE_W-1:0] value,
        input logic [sorttab_pkg::INDEX_W-1:0] index);
        result_t r;
        r = '0;
        case (op)
            sorttab_pkg::OP_APPEND: begin
                if (fill_shadow >= TABLE_DEPTH) begin
                    r.status = sorttab_pkg::ST_FULL;
                end else begin
                    entry_shadow[fill_shadow] = value;
                    fill_shadow++;
                end
            end
            sorttab_pkg::OP_DELETE: begin
                if (index >= fill_shadow) begin
                    r.status = sorttab_pkg::ST_RANGE;
                end else begin
                    for (int k = int'(index); k + 1 < fill_shadow; k++)
                        entry_shadow[k] = entry_shadow[k + 1];
                    fill_shadow--;
                end
            end
            sorttab_pkg::OP_FIND: begin
                for (int k = 0; k < fill_shadow; k++) begin
                    if (entry_shadow[k] == value) begin
                        r.found    = 1'b1;
                        r.position = sorttab_pkg::POSITION_W'(k);
                    end
                end
            end
            sorttab_pkg::OP_SORT: sort_shadow();
            sorttab_pkg::OP_READ: begin
                if (index >= fill_shadow)
                    r.status = sorttab_pkg::ST_RANGE;
                else
                    r.read_value = entry_shadow[index];
            end
            default: ;
        endcase
        r.count = sorttab_pkg::COUNT_W'(fill_shadow);
        return r;
    endfunction

    // Offer one command and hold it until the block takes it
    task automatic send_cmd(input logic [sorttab_pkg::OP_W-1:0]    op,
                            input logic [sorttab_pkg::VALUE_W-1:0] value,
                            input logic [sorttab_pkg::INDEX_W-1:0] index);
        logic [sorttab_pkg::S_TDATA_W-1:0] word;
        int gap;
        word = '0;
        word[sorttab_pkg::VALUE_LSB +: sorttab_pkg::VALUE_W] = value;
        word[sorttab_pkg::INDEX_LSB +: sorttab_pkg::INDEX_W] = index;
        gap = idle_en ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_command(op, value, index));
        cmds_issued++;
    endtask

    // Call right after the last send so valid drops in the acceptance step
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver: a requested hold-off wins over the random gaps
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap--;
        end else begin
            m_tready <= 1'b1;
            if (idle_en)
                rx_gap = gap_len();
        end
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[sorttab_pkg::M_TDATA_BITS-1:0]);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(got), '0);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.found !== want.found)
                    report_mismatch("found", 64'(got.found), 64'(want.found));
                if (got.position !== want.position)
                    report_mismatch("position", 64'(got.position), 64'(want.position));
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", 64'(got.read_value),
                                    64'(want.read_value));
                if (got.count !== want.count)
                    report_mismatch("count", 64'(got.count), 64'(want.count));
            end
        end
    end

    // Empty-table corner cases, unused codes, duplicates, extremes
    task automatic test_directed();
        send_cmd(sorttab_pkg::OP_READ, '0, '0);
        send_cmd(sorttab_pkg::OP_DELETE, '0, '1);
        send_cmd(sorttab_pkg::OP_FIND, '0, '0);
        send_cmd(sorttab_pkg::OP_SORT, '1, '1);
        for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
            send_cmd(sorttab_pkg::OP_W'(c), '1, '1);
        send_cmd(sorttab_pkg::OP_APPEND, '0, '0);
        send_cmd(sorttab_pkg::OP_APPEND, '1, '1);
        send_cmd(sorttab_pkg::OP_APPEND, 32'd5, '0);
        send_cmd(sorttab_pkg::OP_APPEND, '1, '0);
        send_cmd(sorttab_pkg::OP_FIND, '1, '0);
        send_cmd(sorttab_pkg::OP_FIND, 32'd7, '0);
        send_cmd(sorttab_pkg::OP_READ, '0, '1);
        send_cmd(sorttab_pkg::OP_READ, '0, 6'd3);
        send_cmd(sorttab_pkg::OP_SORT, '0, '0);
        send_cmd(sorttab_pkg::OP_READ, '0, 6'd1);
        send_cmd(sorttab_pkg::OP_DELETE, '0, '0);
        send_cmd(sorttab_pkg::OP_DELETE, '0, 6'd3);
        send_cmd(sorttab_pkg::OP_FIND, '0, '0);
        send_cmd(sorttab_pkg::OP_READ, '0, 6'd2);
        send_cmd(sorttab_pkg::OP_DELETE, '0, 6'd2);
        send_cmd(sorttab_pkg::OP_READ, '0, '0);
    endtask

    // Fill to capacity, overflow, then work on a full table
    task automatic test_full_table();
        while (fill_shadow < TABLE_DEPTH)
            send_cmd(sorttab_pkg::OP_APPEND,
                     $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom,
                     sorttab_pkg::INDEX_W'($urandom));
        send_cmd(sorttab_pkg::OP_APPEND, $urandom, sorttab_pkg::INDEX_W'($urandom));
        send_cmd(sorttab_pkg::OP_APPEND, '1, '1);
        send_cmd(sorttab_pkg::OP_SORT, '0, '0);
        send_cmd(sorttab_pkg::OP_READ, '0, '0);
        send_cmd(sorttab_pkg::OP_READ, '0, '1);
        send_cmd(sorttab_pkg::OP_FIND, entry_shadow[17], '0);
        send_cmd(sorttab_pkg::OP_FIND, '1, '0);
        send_cmd(sorttab_pkg::OP_DELETE, '0, '1);
        send_cmd(sorttab_pkg::OP_READ, '0, '1);
        send_cmd(sorttab_pkg::OP_DELETE, '0, '0);
        send_cmd(sorttab_pkg::OP_APPEND, '1, '0);
        send_cmd(sorttab_pkg::OP_APPEND, '1, '0);
        send_cmd(sorttab_pkg::OP_APPEND, '0, '0);
        send_cmd(sorttab_pkg::OP_DELETE, '0, 6'd31);
        send_cmd(sorttab_pkg::OP_READ, '0, 6'd62);
    endtask

    // Hold the receiver off while commands keep coming
    task automatic test_output_stall();
        logic [sorttab_pkg::OP_W-1:0] op;
        idle_en = 1'b0;
        rx_hold = 400;
        repeat (12) begin
            case ($urandom_range(0, 2))
                0:       op = sorttab_pkg::OP_APPEND;
                1:       op = sorttab_pkg::OP_FIND;
                default: op = sorttab_pkg::OP_READ;
            endcase
            send_cmd(op, $urandom_range(0, 3), sorttab_pkg::INDEX_W'($urandom_range(0, 7)));
        end
        wait_idle();
        idle_en = 1'b1;
    endtask

    // Phases steer the fill count toward a goal; content is random
    task automatic test_random_mix(input int n_items);
        int goal;
        int phase_len;
        int r;
        int stop_at;
        logic [sorttab_pkg::OP_W-1:0]    op;
        logic [sorttab_pkg::VALUE_W-1:0] value;
        logic [sorttab_pkg::INDEX_W-1:0] index;
        stop_at = cmds_issued + n_items;
        while (cmds_issued < stop_at) begin
            goal      = ($urandom_range(0, 4) == 0) ? TABLE_DEPTH : $urandom_range(0, 16);
            phase_len = $urandom_range(20, 60);
            idle_en   = ($urandom_range(0, 4) != 0);
            value_pool[0] = '0;
            value_pool[1] = '1;
            for (int p = 2; p < 6; p++)
                value_pool[p] = $urandom;
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    op = sorttab_pkg::OP_SORT;
                else if (r < 8)
                    op = sorttab_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                else if (r < 28)
                    op = sorttab_pkg::OP_FIND;
                else if (r < 46)
                    op = sorttab_pkg::OP_READ;
                else if (fill_shadow < goal || (fill_shadow == goal && $urandom_range(0, 1)))
                    op = sorttab_pkg::OP_APPEND;
                else
                    op = sorttab_pkg::OP_DELETE;

                value = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 5)] : $urandom;
                if (op == sorttab_pkg::OP_FIND && fill_shadow > 0 && $urandom_range(0, 2) != 0)
                    value = entry_shadow[$urandom_range(0, fill_shadow - 1)];

                if (fill_shadow > 0 && $urandom_range(0, 5) != 0)
                    index = sorttab_pkg::INDEX_W'($urandom_range(0, fill_shadow - 1));
                else
                    index = sorttab_pkg::INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));

                send_cmd(op, value, index);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full_table();
        wait_idle();
        test_output_stall();
        test_random_mix(540);
        wait_idle();
        // let any stray result show up before the verdict
        repeat (300) @(posedge aclk);
        if (err_count == 0)
            $display("sortable_element_table_top_tb: PASS");
        else
            $display("sortable_element_table_top_tb: FAIL");
        $finish;
    end

endmodule
